@@ hdl/fdmns_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmns_pkg: shared definitions for the fractional divider M/N search
// Field widths, search limits, status codes and the divider status struct.
// ----------------------------------------------------------------------------
package fdmns_pkg;

	// Field widths
	localparam int RATE_W = 32;
	localparam int M_W    = 9;
	localparam int N_W    = 20;
	localparam int CNT_W  = $clog2(RATE_W);
	// Full quotient of parent*M/rate for any M up to M_MAX
	localparam int NACC_W = RATE_W + M_W;

	// Search limits
	localparam logic [M_W-1:0] M_MAX = M_W'(511);
	localparam logic [N_W-1:0] N_MAX = N_W'(1048575);
	localparam logic [M_W-1:0] M_MIN = M_W'(1);

	// Result status codes
	typedef enum logic [1:0] {
		FIT_EXACT     = 2'd0,
		FIT_APPROX    = 2'd1,
		FIT_NONE      = 2'd2,
		FIT_RATE_ZERO = 2'd3
	} fit_status_t;

	// Divider handshake toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ hdl/fdmns_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmns_div: serial restoring divider
// Produces one quotient bit per cycle; quotient and remainder are valid in
// the cycle that done is high and hold until the next start.
// ----------------------------------------------------------------------------
module fdmns_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fdmns_pkg::RATE_W-1:0] dividend,
	input  logic [fdmns_pkg::RATE_W-1:0] divisor,
	output fdmns_pkg::div_stat_t        stat,
	output logic [fdmns_pkg::RATE_W-1:0] quotient,
	output logic [fdmns_pkg::RATE_W-1:0] remainder
);
	import fdmns_pkg::*;

	logic [RATE_W-1:0] quo_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [RATE_W:0]   rem_sh;
	logic [RATE_W+1:0] trial;
	logic              fits;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		rem_sh = {rem_q, quo_q[RATE_W-1]};
		trial  = {1'b0, rem_sh} - {2'b00, dsr_q};
		fits   = ~trial[RATE_W+1];
	end

	// Control: count the steps, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RATE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[RATE_W-2:0], fits};
			rem_q <= fits ? trial[RATE_W-1:0] : rem_sh[RATE_W-1:0];
		end
	end

	assign stat      = '{busy: busy_q, done: done_q};
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ hdl/fractional_divider_mn_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_divider_mn_search: M/N term search for a fractional divider
// For each accepted request the search runs the serial division, then a check
// of parent/rate; when the parent rate is an exact multiple of rate that fits,
// the result register is then loaded. Otherwise the check is followed by a
// scan over all 511 values of M, from 1 to 511, and then the load of the result
// register. A zero rate skips the division and goes straight to the load of
// the result register. The search runs on the serial divider and the single
// step-per-M scan datapath, which tracks N and the remainder of parent*M/rate
// by adding the quotient and remainder of parent/rate once per step. The
// request side stalls from acceptance until the result is handed to the
// output register; a finished result can wait on the output while the next
// request is accepted. post_divider is constant 1.
// ----------------------------------------------------------------------------
module fractional_divider_mn_search (
	input  logic                         clk,
	input  logic                         arst_n,
	// Request channel
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [fdmns_pkg::RATE_W-1:0] rate,
	input  logic [fdmns_pkg::RATE_W-1:0] src_rate,
	// Result channel
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [fdmns_pkg::M_W-1:0]    m_value,
	output logic [fdmns_pkg::N_W-1:0]    n_value,
	output logic                         post_divider,
	output logic [fdmns_pkg::RATE_W-1:0] residue,
	output logic [1:0]                   status
);
	import fdmns_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIVIDE,
		S_CHECK,
		S_SCAN,
		S_DONE
	} state_t;

	state_t            state_q;

	// Request and division results
	logic [RATE_W-1:0] rate_q;
	logic [RATE_W-1:0] q0_q;
	logic [RATE_W-1:0] r0_q;
	logic [RATE_W-1:0] rc_q;

	// Scan point
	logic [M_W-1:0]    m_q;
	logic [NACC_W-1:0] n_q;
	logic [RATE_W-1:0] r_q;

	// Best pair so far
	logic              found_q;
	logic [M_W-1:0]    best_m_q;
	logic [N_W-1:0]    best_n_q;
	logic [RATE_W-1:0] best_r_q;

	// Pending result
	logic [M_W-1:0]    pm_q;
	logic [N_W-1:0]    pn_q;
	logic [RATE_W-1:0] pr_q;
	fit_status_t       ps_q;

	// Output register
	logic              res_valid_q;
	logic [M_W-1:0]    m_out_q;
	logic [N_W-1:0]    n_out_q;
	logic [RATE_W-1:0] r_out_q;
	fit_status_t       s_out_q;

	logic              req_accept;
	logic              div_start;
	div_stat_t         div_stat;
	logic [RATE_W-1:0] div_quo;
	logic [RATE_W-1:0] div_rem;

	logic              direct_fit;
	logic              pair_ok;
	logic              take_pair;
	logic [RATE_W:0]   r_sub;
	logic              wrap;
	logic [RATE_W-1:0] r_next;
	logic [NACC_W-1:0] n_next;
	logic              nf_found;
	logic [M_W-1:0]    nf_m;
	logic [N_W-1:0]    nf_n;
	logic [RATE_W-1:0] nf_r;
	logic              out_free;
	logic              out_load;

	assign req_stall  = (state_q != S_IDLE);
	assign req_accept = req_valid & ~req_stall;
	assign div_start  = req_accept & (rate != '0);
	assign out_free   = ~res_valid_q | ~res_stall;
	assign out_load   = (state_q == S_DONE) & out_free;

	fdmns_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (src_rate),
		.divisor   (rate),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Direct multiple test on parent/rate
	assign direct_fit = (r0_q == '0) && (q0_q >= RATE_W'(2))
		&& (q0_q <= RATE_W'(N_MAX));

	// Qualify the current scan point and fold it into the best pair
	always_comb begin
		pair_ok   = (n_q >= NACC_W'({m_q, 1'b0})) && (n_q <= NACC_W'(N_MAX));
		take_pair = pair_ok && (!found_q || (r_q <= best_r_q));
		nf_found  = found_q | pair_ok;
		nf_m      = take_pair ? m_q : best_m_q;
		nf_n      = take_pair ? n_q[N_W-1:0] : best_n_q;
		nf_r      = take_pair ? r_q : best_r_q;
	end

	// Advance to M+1: add parent/rate, carry when the remainder wraps
	always_comb begin
		r_sub  = {1'b0, r_q} - {1'b0, rc_q};
		wrap   = ~r_sub[RATE_W];
		r_next = wrap ? r_sub[RATE_W-1:0] : (r_q + r0_q);
		n_next = n_q + NACC_W'(q0_q) + NACC_W'(wrap);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						if (rate == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIVIDE;
						end
					end
				end
				S_DIVIDE: begin
					if (div_stat.done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					found_q <= 1'b0;
					if (direct_fit) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					found_q <= nf_found;
					if (m_q == M_MAX) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					rate_q <= rate;
					pm_q   <= '0;
					pn_q   <= '0;
					pr_q   <= '0;
					ps_q   <= FIT_RATE_ZERO;
				end
			end
			S_DIVIDE: begin
				if (div_stat.done) begin
					q0_q <= div_quo;
					r0_q <= div_rem;
				end
			end
			S_CHECK: begin
				// Start the scan at M = 1
				m_q  <= M_MIN;
				n_q  <= NACC_W'(q0_q);
				r_q  <= r0_q;
				rc_q <= rate_q - r0_q;
				pm_q <= M_MIN;
				pn_q <= q0_q[N_W-1:0];
				pr_q <= '0;
				ps_q <= FIT_EXACT;
			end
			S_SCAN: begin
				best_m_q <= nf_m;
				best_n_q <= nf_n;
				best_r_q <= nf_r;
				m_q      <= m_q + M_W'(1);
				n_q      <= n_next;
				r_q      <= r_next;
				if (m_q == M_MAX) begin
					if (nf_found) begin
						pm_q <= nf_m;
						pn_q <= nf_n;
						pr_q <= nf_r;
						ps_q <= (nf_r == '0) ? FIT_EXACT : FIT_APPROX;
					end else begin
						pm_q <= '0;
						pn_q <= '0;
						pr_q <= '0;
						ps_q <= FIT_NONE;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_out_q <= pm_q;
					n_out_q <= pn_q;
					r_out_q <= pr_q;
					s_out_q <= ps_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid    = res_valid_q;
	assign m_value      = m_out_q;
	assign n_value      = n_out_q;
	assign post_divider = 1'b1;
	assign residue      = r_out_q;
	assign status       = s_out_q;

endmodule
